// File: rtl/stick_dead_zone_normalizer_assert.svh
// Assertion macros for the stick dead zone normalizer
`ifndef STICK_DEAD_ZONE_NORMALIZER_ASSERT_SVH
`define STICK_DEAD_ZONE_NORMALIZER_ASSERT_SVH

// same-cycle implication
`define SDZN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdzn assertion failed");

// next-cycle implication
`define SDZN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdzn assertion failed");

`endif

// File: rtl/sdzn_pkg.sv
// Package: constants, register map and step functions for the dead zone normalizer
package sdzn_pkg;

    localparam int LAT = 36;
    localparam int TRIG_DLY = LAT - 16;

    localparam logic [1:0] REG_LEFT_DZ  = 2'd0;
    localparam logic [1:0] REG_RIGHT_DZ = 2'd1;
    localparam logic [1:0] REG_THR      = 2'd2;

    localparam logic [14:0] LEFT_DZ_RST  = 15'd7849;
    localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;
    localparam logic [7:0]  THR_RST      = 8'd30;

    localparam logic [14:0] AXIS_MAX = 15'h7FFF;
    localparam logic [7:0]  TRIG_FULL = 8'hFF;

    typedef struct packed {
        logic [31:0] v;
        logic [31:0] r;
    } t_sq;

    typedef struct packed {
        logic        b;
        logic [31:0] rem;
    } t_dstep;

    // one step of the digit-by-digit integer square root
    function automatic t_sq sqrt_step(input logic [31:0] v, input logic [31:0] r,
                                      input logic [4:0] idx);
        logic [31:0] bitv;
        logic [31:0] trial;
        t_sq         o;
        bitv  = 32'd1 << {idx, 1'b0};
        trial = r + bitv;
        if (v >= trial) begin
            o.v = v - trial;
            o.r = (r >> 1) + bitv;
        end else begin
            o.v = v;
            o.r = r >> 1;
        end
        return o;
    endfunction

    // one restoring division step, rem < den
    function automatic t_dstep div_step(input logic [31:0] rem, input logic [31:0] den);
        logic [31:0] r2;
        t_dstep      o;
        r2 = {rem[30:0], 1'b0};
        if (r2 >= den) begin
            o.b   = 1'b1;
            o.rem = r2 - den;
        end else begin
            o.b   = 1'b0;
            o.rem = r2;
        end
        return o;
    endfunction

endpackage

// File: rtl/stick_dead_zone_normalizer.sv
// Top level: controller report dead zone normalizer with APB register port
//
// Input channel (i_in_valid / o_in_ready) takes one report word: two signed
// stick pairs and two 8-bit triggers. Output channel (o_out_valid /
// i_out_ready) returns the normalized word in Q1.15 / Q0.15.
// One word per cycle is sustained while the output is not stalled. The
// 16-stage square root and the 15-stage divide pipelines set the
// latency.
// The pipeline advances as a whole whenever the output register is empty
// or being taken; when the receiver stalls with a word held at the output,
// every stage holds and o_in_ready drops, so nothing is lost or repeated.
// Reset clears all valid bits and loads the dead zone registers (7849,
// 8689) and the trigger threshold (30). Registers sit at 0x0, 0x4, 0x8, and
// the user writes them only while no word is in flight (not enforced).
module stick_dead_zone_normalizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_left_x,
    input  logic signed [15:0] i_left_y,
    input  logic signed [15:0] i_right_x,
    input  logic signed [15:0] i_right_y,
    input  logic [7:0]         i_left_trigger,
    input  logic [7:0]         i_right_trigger,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_left_x_norm,
    output logic signed [15:0] o_left_y_norm,
    output logic signed [15:0] o_right_x_norm,
    output logic signed [15:0] o_right_y_norm,
    output logic [14:0]        o_left_trigger_norm,
    output logic [14:0]        o_right_trigger_norm,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    `include "stick_dead_zone_normalizer_assert.svh"

    logic [14:0] r_ldz, r_rdz;
    logic [7:0]  r_thr;
    logic [sdzn_pkg::LAT-1:0] r_vld, n_vld;
    logic        w_en;
    logic        w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ldz <= sdzn_pkg::LEFT_DZ_RST;
            r_rdz <= sdzn_pkg::RIGHT_DZ_RST;
            r_thr <= sdzn_pkg::THR_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                sdzn_pkg::REG_LEFT_DZ:  r_ldz <= pwdata[14:0];
                sdzn_pkg::REG_RIGHT_DZ: r_rdz <= pwdata[14:0];
                sdzn_pkg::REG_THR:      r_thr <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            sdzn_pkg::REG_LEFT_DZ:  prdata = {17'd0, r_ldz};
            sdzn_pkg::REG_RIGHT_DZ: prdata = {17'd0, r_rdz};
            sdzn_pkg::REG_THR:      prdata = {24'd0, r_thr};
            default:                prdata = '0;
        endcase
    end

    assign w_en       = !r_vld[sdzn_pkg::LAT-1] || i_out_ready;
    assign o_in_ready = w_en;
    assign n_vld      = {r_vld[sdzn_pkg::LAT-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    assign o_out_valid = r_vld[sdzn_pkg::LAT-1];

    sdzn_stick u_left (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (i_left_x),
        .i_y   (i_left_y),
        .i_dz  (r_ldz),
        .o_x   (o_left_x_norm),
        .o_y   (o_left_y_norm)
    );

    sdzn_stick u_right (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (i_right_x),
        .i_y   (i_right_y),
        .i_dz  (r_rdz),
        .o_x   (o_right_x_norm),
        .o_y   (o_right_y_norm)
    );

    sdzn_trig u_ltrig (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_t   (i_left_trigger),
        .i_thr (r_thr),
        .o_t   (o_left_trigger_norm)
    );

    sdzn_trig u_rtrig (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_t   (i_right_trigger),
        .i_thr (r_thr),
        .o_t   (o_right_trigger_norm)
    );

    `SDZN_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_in_valid && o_in_ready, r_vld[0])
    `SDZN_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, !w_en, r_vld == $past(r_vld))
    `SDZN_ASSERT_IMP(a_no_min_lx, i_clk, i_rst_n, o_out_valid, o_left_x_norm != 16'sh8000)
    `SDZN_ASSERT_IMP(a_no_min_rx, i_clk, i_rst_n, o_out_valid, o_right_x_norm != 16'sh8000)

endmodule

// File: rtl/sdzn_stick.sv
// Stick lane: square, radial compare, pipelined sqrt, scale and pipelined divide
module sdzn_stick (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic [14:0]        i_dz,
    output logic signed [15:0] o_x,
    output logic signed [15:0] o_y
);

    typedef struct packed {
        logic [16:0] ax;
        logic [16:0] ay;
        logic        nx;
        logic        ny;
        logic        zero;
    } t_tag;

    typedef struct packed {
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] den;
        logic [14:0] qx;
        logic [14:0] qy;
        logic        sx;
        logic        sy;
    } t_div;

    logic [16:0] w_ax, w_ay;
    logic [16:0] r_ax, r_ay;
    logic        r_nx, r_ny;
    logic [31:0] r_sqx, r_sqy;
    logic [31:0] r2_sum;
    logic [29:0] w_dd;
    t_tag        r_tag [34];
    logic [31:0] r_sv [16];
    logic [31:0] r_sr [16];
    logic [31:0] w_sv_in [16];
    logic [31:0] w_sr_in [16];
    logic [15:0] w_mag;
    logic [15:0] w_magd;
    logic [31:0] r_nxp, r_nyp, r_den;
    t_div        r_dv [16];
    logic signed [15:0] r_ox, r_oy;

    assign w_ax = i_x[15] ? (17'd0 - {i_x[15], i_x}) : {1'b0, i_x};
    assign w_ay = i_y[15] ? (17'd0 - {i_y[15], i_y}) : {1'b0, i_y};
    assign w_dd = {15'd0, i_dz} * {15'd0, i_dz};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax   <= w_ax;
            r_ay   <= w_ay;
            r_nx   <= i_x[15];
            r_ny   <= i_y[15];
            r_sqx  <= {15'd0, w_ax} * {15'd0, w_ax};
            r_sqy  <= {15'd0, w_ay} * {15'd0, w_ay};
            r2_sum <= r_sqx + r_sqy;
            r_tag[0].ax   <= r_ax;
            r_tag[0].ay   <= r_ay;
            r_tag[0].nx   <= r_nx;
            r_tag[0].ny   <= r_ny;
            r_tag[0].zero <= ((r_sqx + r_sqy) <= {2'd0, w_dd});
        end
    end

    for (genvar k = 1; k < 34; k++) begin : g_tag
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign w_sv_in[0] = r2_sum;
    assign w_sr_in[0] = '0;
    for (genvar j = 0; j < 16; j++) begin : g_sqrt
        if (j > 0) begin : g_link
            assign w_sv_in[j] = r_sv[j-1];
            assign w_sr_in[j] = r_sr[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                {r_sv[j], r_sr[j]} <= sdzn_pkg::sqrt_step(w_sv_in[j], w_sr_in[j], 5'(15 - j));
            end
        end
    end

    assign w_mag  = r_sr[15][15:0];
    assign w_magd = w_mag - {1'b0, i_dz};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nxp <= {15'd0, r_tag[16].ax} * {16'd0, w_magd};
            r_nyp <= {15'd0, r_tag[16].ay} * {16'd0, w_magd};
            r_den <= {16'd0, w_mag} * {17'd0, sdzn_pkg::AXIS_MAX - i_dz};
            r_dv[0].rx  <= r_nxp;
            r_dv[0].ry  <= r_nyp;
            // zero divisor: all ones gives a zero quotient, saturation covers the rest
            r_dv[0].den <= (r_den == 32'd0) ? '1 : r_den;
            r_dv[0].qx  <= '0;
            r_dv[0].qy  <= '0;
            r_dv[0].sx  <= (r_nxp != 32'd0) && (r_nxp >= r_den);
            r_dv[0].sy  <= (r_nyp != 32'd0) && (r_nyp >= r_den);
        end
    end

    for (genvar j = 1; j < 16; j++) begin : g_div
        sdzn_pkg::t_dstep w_stx, w_sty;
        assign w_stx = sdzn_pkg::div_step(r_dv[j-1].rx, r_dv[j-1].den);
        assign w_sty = sdzn_pkg::div_step(r_dv[j-1].ry, r_dv[j-1].den);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[j].rx  <= w_stx.rem;
                r_dv[j].ry  <= w_sty.rem;
                r_dv[j].den <= r_dv[j-1].den;
                r_dv[j].qx  <= {r_dv[j-1].qx[13:0], w_stx.b};
                r_dv[j].qy  <= {r_dv[j-1].qy[13:0], w_sty.b};
                r_dv[j].sx  <= r_dv[j-1].sx;
                r_dv[j].sy  <= r_dv[j-1].sy;
            end
        end
    end

    function automatic logic [15:0] enc(input logic [14:0] q, input logic sat,
                                        input logic zero, input logic neg);
        logic [15:0] m;
        m = zero ? 16'd0 : (sat ? {1'b0, sdzn_pkg::AXIS_MAX} : {1'b0, q});
        return neg ? (16'd0 - m) : m;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ox <= enc(r_dv[15].qx, r_dv[15].sx, r_tag[33].zero, r_tag[33].nx);
            r_oy <= enc(r_dv[15].qy, r_dv[15].sy, r_tag[33].zero, r_tag[33].ny);
        end
    end

    assign o_x = r_ox;
    assign o_y = r_oy;

endmodule

// File: rtl/sdzn_trig.sv
// Trigger lane: threshold, pipelined divide and delay to match the stick lanes
module sdzn_trig (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [7:0]  i_t,
    input  logic [7:0]  i_thr,
    output logic [14:0] o_t
);

    typedef struct packed {
        logic [7:0]  rem;
        logic [7:0]  den;
        logic [14:0] q;
        logic        sat;
        logic        pos;
    } t_tdiv;

    t_tdiv       r_tv [16];
    logic [14:0] r_o [sdzn_pkg::TRIG_DLY];
    logic [7:0]  w_n;
    logic [7:0]  w_den;

    assign w_n   = i_t - i_thr;
    assign w_den = sdzn_pkg::TRIG_FULL - i_thr;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tv[0].rem <= w_n;
            r_tv[0].den <= w_den;
            r_tv[0].q   <= '0;
            r_tv[0].pos <= (i_t > i_thr);
            r_tv[0].sat <= (i_t > i_thr) && (w_n >= w_den);
        end
    end

    for (genvar j = 1; j < 16; j++) begin : g_div
        logic [8:0] w_r2;
        logic       w_b;
        assign w_r2 = {r_tv[j-1].rem, 1'b0};
        assign w_b  = (w_r2 >= {1'b0, r_tv[j-1].den});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tv[j].rem <= w_b ? 8'(w_r2 - {1'b0, r_tv[j-1].den}) : w_r2[7:0];
                r_tv[j].den <= r_tv[j-1].den;
                r_tv[j].q   <= {r_tv[j-1].q[13:0], w_b};
                r_tv[j].sat <= r_tv[j-1].sat;
                r_tv[j].pos <= r_tv[j-1].pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o[0] <= !r_tv[15].pos ? 15'd0 :
                      (r_tv[15].sat ? sdzn_pkg::AXIS_MAX : r_tv[15].q);
        end
    end

    for (genvar k = 1; k < sdzn_pkg::TRIG_DLY; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_o[k] <= r_o[k-1];
            end
        end
    end

    assign o_t = r_o[sdzn_pkg::TRIG_DLY-1];

endmodule
